// ===== rtl/msl_pkg.sv =====
// package for the music script lexer: token kinds, scan modes, item types
package msl_pkg;

	localparam int PositionBitsDef = 16;
	localparam int KeywordCharsDef = 6;
	localparam int QueueDepth = 4;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_SLASH, M_BANG, M_EQUAL, M_LESS, M_GREATER,
		M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_IDENT
	} scan_mode_t;

	localparam logic [5:0] K_END = 6'd0;
	localparam logic [5:0] K_EOL = 6'd1;
	localparam logic [5:0] K_AMP = 6'd2;
	localparam logic [5:0] K_PIPE = 6'd3;
	localparam logic [5:0] K_CARET = 6'd4;
	localparam logic [5:0] K_LPAR = 6'd5;
	localparam logic [5:0] K_RPAR = 6'd6;
	localparam logic [5:0] K_LBRACE = 6'd7;
	localparam logic [5:0] K_RBRACE = 6'd8;
	localparam logic [5:0] K_LBRACK = 6'd9;
	localparam logic [5:0] K_RBRACK = 6'd10;
	localparam logic [5:0] K_DOT = 6'd11;
	localparam logic [5:0] K_COMMA = 6'd12;
	localparam logic [5:0] K_BANG = 6'd13;
	localparam logic [5:0] K_MINUS = 6'd21;
	localparam logic [5:0] K_PLUS = 6'd22;
	localparam logic [5:0] K_STAR = 6'd23;
	localparam logic [5:0] K_SLASH = 6'd24;
	localparam logic [5:0] K_PERCENT = 6'd25;
	localparam logic [5:0] K_DOLLAR = 6'd26;
	localparam logic [5:0] K_NUMBER = 6'd27;
	localparam logic [5:0] K_IDENT = 6'd28;
	localparam logic [5:0] K_NOTE_LETTER = 6'd29;
	localparam logic [5:0] K_PRINT = 6'd30;
	localparam logic [5:0] K_PTN = 6'd31;
	localparam logic [5:0] K_RAN = 6'd32;
	localparam logic [5:0] K_RETURN = 6'd33;
	localparam logic [5:0] K_EUC = 6'd34;
	localparam logic [5:0] K_KW_END = 6'd35;
	localparam logic [5:0] K_FN = 6'd36;
	localparam logic [5:0] K_DUR = 6'd37;
	localparam logic [5:0] K_NOTE = 6'd38;
	localparam logic [5:0] K_CC = 6'd39;
	localparam logic [5:0] K_ERROR = 6'd40;

	// one byte item, classified by the front part
	typedef struct packed {
		logic [7:0] data_byte;
		logic       at_end;
		logic       is_alpha;
		logic       is_digit;
		logic       is_space;
		logic       is_ident_tail;
		logic [5:0] single_kind; // K_ERROR when not a one-byte operator
	} byte_cls_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [15:0] line_number;
		logic [7:0]  bad_byte;
		logic        last_of_run;
	} token_t;

	function automatic logic [5:0] single_kind_of(input logic [7:0] b);
		case (b)
			8'h26: single_kind_of = K_AMP;
			8'h7c: single_kind_of = K_PIPE;
			8'h5e: single_kind_of = K_CARET;
			8'h28: single_kind_of = K_LPAR;
			8'h29: single_kind_of = K_RPAR;
			8'h7b: single_kind_of = K_LBRACE;
			8'h7d: single_kind_of = K_RBRACE;
			8'h5b: single_kind_of = K_LBRACK;
			8'h5d: single_kind_of = K_RBRACK;
			8'h2e: single_kind_of = K_DOT;
			8'h2c: single_kind_of = K_COMMA;
			8'h2d: single_kind_of = K_MINUS;
			8'h2b: single_kind_of = K_PLUS;
			8'h2a: single_kind_of = K_STAR;
			8'h25: single_kind_of = K_PERCENT;
			8'h24: single_kind_of = K_DOLLAR;
			default: single_kind_of = K_ERROR;
		endcase
	endfunction

endpackage

// ===== rtl/msl_if.sv =====
// valid/ready channel interfaces for byte items and token items
interface msl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;
	modport source (output valid, data_byte, end_of_input, input ready);
	modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface msl_token_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic [7:0]  bad_byte;
	logic        last_of_run;
	modport source (output valid, token_kind, token_start, token_length, line_number,
		bad_byte, last_of_run, input ready);
	modport sink (input valid, token_kind, token_start, token_length, line_number,
		bad_byte, last_of_run, output ready);
endinterface

// ===== rtl/msl_front.sv =====
// front part: accepts byte items, classifies them and queues them
module msl_front import msl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	msl_byte_if.sink   in_ch,
	output byte_cls_t  q_data,
	output logic       q_valid,
	input  logic       q_pop
);
	localparam int AW = $clog2(QueueDepth);

	byte_cls_t mem_q [QueueDepth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	byte_cls_t cls;
	logic push;
	logic [7:0] b;

	assign b = in_ch.data_byte;
	always_comb begin
		cls.data_byte = b;
		cls.at_end = in_ch.end_of_input || (b == 8'h00);
		cls.is_alpha = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
		cls.is_digit = (b >= 8'h30 && b <= 8'h39);
		cls.is_space = (b == 8'h20) || (b == 8'h09) || (b == 8'h0d);
		cls.is_ident_tail = cls.is_alpha || cls.is_digit || b == 8'h23;
		cls.single_kind = single_kind_of(b);
	end

	assign in_ch.ready = (cnt_q != (AW+1)'(QueueDepth));
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != '0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

// ===== rtl/msl_back.sv =====
// back part: scan state machine, emits up to three tokens per byte item
module msl_back import msl_pkg::*; #(
	parameter int POSITION_BITS = PositionBitsDef,
	parameter int KEYWORD_CHARS = KeywordCharsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  byte_cls_t q_data,
	input  logic      q_valid,
	output logic      q_pop,
	msl_token_if.source out_ch
);
	localparam int PB = POSITION_BITS;
	localparam int KW = KEYWORD_CHARS * 8;
	localparam logic [PB-1:0] PosMax = '1;

	scan_mode_t mode_q, mode_d;
	logic [PB-1:0] off_q, off_d, beg_q, beg_d, line_q, line_d, len_q, len_d;
	logic [KW-1:0] pfx_q, pfx_d;
	logic stop_q, stop_d;

	// up to three tokens from one item, shown one per cycle while the output is ready
	token_t tok [3];
	logic [1:0] ntok, idx_q;
	logic busy_q;
	token_t slot_q [3];
	logic [1:0] cnt_q;

	function automatic logic [PB-1:0] sat(input logic [PB-1:0] a, input logic [1:0] d);
		logic [PB:0] s;
		s = {1'b0, a} + (PB+1)'(d);
		sat = s[PB] ? PosMax : s[PB-1:0];
	endfunction

	function automatic logic [PB-1:0] sat_add_full(input logic [PB-1:0] a,
		input logic [PB-1:0] d);
		logic [PB:0] s;
		s = {1'b0, a} + {1'b0, d};
		sat_add_full = s[PB] ? PosMax : s[PB-1:0];
	endfunction

	function automatic logic [15:0] lo16(input logic [PB-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		lo16 = w[15:0];
	endfunction

	function automatic logic [7:0] pch(input logic [KW-1:0] p, input int i);
		pch = p[i*8 +: 8];
	endfunction

	function automatic logic [5:0] classify(input logic [KW-1:0] p, input logic [PB-1:0] l);
		logic [5:0] k;
		logic [7:0] c0, c1, c2, c3, c4, c5;
		c0 = pch(p, 0); c1 = pch(p, 1); c2 = pch(p, 2);
		c3 = pch(p, 3); c4 = pch(p, 4); c5 = pch(p, 5);
		k = K_IDENT;
		if (c0 >= 8'h41 && c0 <= 8'h47) k = K_NOTE_LETTER;
		else if (l == PB'(5) && c0 == "p" && c1 == "r" && c2 == "i" && c3 == "n" && c4 == "t")
			k = K_PRINT;
		else if (l == PB'(3) && c0 == "p" && c1 == "t" && c2 == "n") k = K_PTN;
		else if (l == PB'(3) && c0 == "r" && c1 == "a" && c2 == "n") k = K_RAN;
		else if (l == PB'(6) && c0 == "r" && c1 == "e" && c2 == "t" && c3 == "u"
			&& c4 == "r" && c5 == "n") k = K_RETURN;
		else if (l == PB'(3) && c0 == "e" && c1 == "u" && c2 == "c") k = K_EUC;
		else if (l == PB'(3) && c0 == "e" && c1 == "n" && c2 == "d") k = K_KW_END;
		else if (l == PB'(2) && c0 == "f" && c1 == "n") k = K_FN;
		else if (l == PB'(2) && c0 == "n" && (c1 == "1" || c1 == "2" || c1 == "4"
			|| c1 == "8")) k = K_DUR;
		else if (l == PB'(3) && c0 == "n" && ((c1 == "1" && c2 == "6")
			|| (c1 == "3" && c2 == "2"))) k = K_DUR;
		else if (l == PB'(4) && c0 == "n" && c1 == "o" && c2 == "t" && c3 == "e") k = K_NOTE;
		else if (l == PB'(2) && c0 == "c" && c1 == "c") k = K_CC;
		classify = k;
	endfunction

	function automatic token_t mk(input logic [5:0] k, input logic [PB-1:0] s,
		input logic [PB-1:0] l, input logic [PB-1:0] ln, input logic [7:0] bb);
		token_t t;
		t.token_kind = k;
		t.token_start = lo16(s);
		t.token_length = lo16(l);
		t.line_number = lo16(ln);
		t.bad_byte = bb;
		t.last_of_run = 1'b0;
		mk = t;
	endfunction

	logic accept;
	assign accept = q_valid && (!busy_q || (out_ch.ready && idx_q == cnt_q - 2'd1));
	assign q_pop = accept;

	always_comb begin
		logic taken;
		logic [7:0] b;
		byte_cls_t c;
		logic [PB-1:0] pos;
		c = q_data;
		b = c.data_byte;
		pos = off_q;
		taken = 1'b0;
		mode_d = mode_q; off_d = off_q; beg_d = beg_q; line_d = line_q;
		len_d = len_q; pfx_d = pfx_q; stop_d = stop_q;
		ntok = 2'd0;
		for (int i = 0; i < 3; i++) tok[i] = mk(K_END, '0, '0, '0, 8'h00);

		// after an error nothing is emitted, not even at the end of the file
		if (!stop_q) begin
			if (!c.at_end) begin
				case (mode_q)
					M_COMMENT: begin
						taken = (b != 8'h0a);
						if (!taken) mode_d = M_IDLE;
					end
					M_SLASH: if (b == 8'h2f) begin
						mode_d = M_COMMENT; taken = 1'b1;
					end
					M_BANG, M_EQUAL, M_LESS, M_GREATER: if (b == 8'h3d) begin
						tok[0] = mk(K_BANG + 6'd1 + 6'(2 * (mode_q - M_BANG)), beg_q,
							PB'(2), line_q, 8'h00);
						ntok = 2'd1; mode_d = M_IDLE; taken = 1'b1;
					end
					M_NUM_INT: if (c.is_digit) begin
						len_d = sat(len_q, 2'd1); taken = 1'b1;
					end else if (b == 8'h2e) begin
						mode_d = M_NUM_DOT; taken = 1'b1;
					end
					M_NUM_DOT: if (c.is_digit) begin
						len_d = sat(len_q, 2'd2); mode_d = M_NUM_FRAC; taken = 1'b1;
					end
					M_NUM_FRAC: if (c.is_digit) begin
						len_d = sat(len_q, 2'd1); taken = 1'b1;
					end
					M_IDENT: if (c.is_ident_tail) begin
						for (int i = 1; i < KEYWORD_CHARS; i++)
							if (len_q == PB'(i)) pfx_d[i*8 +: 8] = b;
						len_d = sat(len_q, 2'd1); taken = 1'b1;
					end
					default: ;
				endcase
			end
			if (!taken) begin
				// flush the pending token
				case (mode_q)
					M_SLASH: begin
						tok[ntok] = mk(K_SLASH, beg_q, PB'(1), line_q, 8'h00);
						ntok = ntok + 2'd1;
					end
					M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
						tok[ntok] = mk(K_BANG + 6'(2 * (mode_q - M_BANG)), beg_q, PB'(1),
							line_q, 8'h00);
						ntok = ntok + 2'd1;
					end
					M_NUM_INT, M_NUM_FRAC: begin
						tok[ntok] = mk(K_NUMBER, beg_q, len_q, line_q, 8'h00);
						ntok = ntok + 2'd1;
					end
					M_NUM_DOT: begin
						tok[ntok] = mk(K_NUMBER, beg_q, len_q, line_q, 8'h00);
						tok[ntok + 2'd1] = mk(K_DOT, sat_add_full(beg_q, len_q), PB'(1),
							line_q, 8'h00);
						ntok = ntok + 2'd2;
					end
					M_IDENT: begin
						tok[ntok] = mk(len_q > PB'(KEYWORD_CHARS) &&
							!(pch(pfx_q, 0) >= 8'h41 && pch(pfx_q, 0) <= 8'h47)
							? K_IDENT : classify(pfx_q, len_q), beg_q, len_q, line_q, 8'h00);
						ntok = ntok + 2'd1;
					end
					default: ;
				endcase
				mode_d = M_IDLE;
				if (c.at_end) begin
					tok[ntok] = mk(K_END, off_q, '0, line_q, 8'h00);
					ntok = ntok + 2'd1;
				end else begin
					beg_d = pos;
					len_d = PB'(1);
					if (c.is_space) begin
					end else if (b == 8'h0a) begin
						tok[ntok] = mk(K_EOL, pos, PB'(1), line_q, 8'h00);
						ntok = ntok + 2'd1;
						line_d = sat(line_q, 2'd1);
					end else if (c.is_alpha) begin
						mode_d = M_IDENT;
						pfx_d = KW'(b);
					end else if (c.is_digit) mode_d = M_NUM_INT;
					else if (b == 8'h2f) mode_d = M_SLASH;
					else if (b == 8'h21) mode_d = M_BANG;
					else if (b == 8'h3d) mode_d = M_EQUAL;
					else if (b == 8'h3c) mode_d = M_LESS;
					else if (b == 8'h3e) mode_d = M_GREATER;
					else if (c.single_kind != K_ERROR) begin
						tok[ntok] = mk(c.single_kind, pos, PB'(1), line_q, 8'h00);
						ntok = ntok + 2'd1;
					end else begin
						stop_d = 1'b1;
						tok[ntok] = mk(K_ERROR, pos, '0, line_q, b);
						ntok = ntok + 2'd1;
					end
				end
			end
			if (!c.at_end) off_d = sat(off_q, 2'd1);
		end
		if (c.at_end) begin
			mode_d = M_IDLE; off_d = '0; beg_d = '0; line_d = PB'(1);
			len_d = '0; pfx_d = '0; stop_d = 1'b0;
		end
		// mark the final token of this item
		for (int i = 0; i < 3; i++) tok[i].last_of_run = (2'(i) == ntok - 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; off_q <= '0; beg_q <= '0; line_q <= PB'(1);
			len_q <= '0; pfx_q <= '0; stop_q <= 1'b0;
			busy_q <= 1'b0; idx_q <= '0; cnt_q <= '0;
		end else begin
			if (busy_q && out_ch.ready) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == cnt_q - 2'd1) busy_q <= 1'b0;
			end
			if (accept) begin
				mode_q <= mode_d; off_q <= off_d; beg_q <= beg_d; line_q <= line_d;
				len_q <= len_d; pfx_q <= pfx_d; stop_q <= stop_d;
				busy_q <= (ntok != 2'd0);
				idx_q <= '0;
				cnt_q <= ntok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) slot_q[i] <= tok[i];
		end
	end

	assign out_ch.valid = busy_q;
	assign out_ch.token_kind = slot_q[idx_q].token_kind;
	assign out_ch.token_start = slot_q[idx_q].token_start;
	assign out_ch.token_length = slot_q[idx_q].token_length;
	assign out_ch.line_number = slot_q[idx_q].line_number;
	assign out_ch.bad_byte = slot_q[idx_q].bad_byte;
	assign out_ch.last_of_run = slot_q[idx_q].last_of_run;
endmodule

// ===== rtl/music_script_lexer_core.sv =====
// top level of the music script lexer
// Byte-stream lexer: one byte item enters per cycle into a four-entry classify queue
// (front) while it is not full, and the scan state machine (back) takes one byte per
// cycle when it is not held, producing up to three tokens that leave one per cycle from
// the output register while the output is ready. A byte that gives tokens holds the back
// part until its last token is taken, while the queue keeps accepting until it is full. A
// zero byte or end_of_input ends the file and restarts the counters; unless an error
// stopped the scan, it also flushes the pending token and emits END. Positions, lengths
// and the line count saturate at 2^POSITION_BITS-1; outputs carry their low 16 bits.
module music_script_lexer_core import msl_pkg::*; #(
	parameter int POSITION_BITS = PositionBitsDef,
	parameter int KEYWORD_CHARS = KeywordCharsDef
) (
	input  logic clk,
	input  logic arst_n,
	msl_byte_if.sink    in_ch,
	msl_token_if.source out_ch
);
	// classified byte queue between front and back
	byte_cls_t q_data;
	logic q_valid, q_pop;

	msl_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	msl_back #(.POSITION_BITS(POSITION_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_data(q_data), .q_valid(q_valid),
		.q_pop(q_pop), .out_ch(out_ch)
	);
endmodule

// ===== rtl/msl_checker.sv =====
// port-level checks for the music script lexer
module msl_checker import msl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [5:0] token_kind,
	input logic [15:0] token_length,
	input logic [7:0] bad_byte,
	input logic last_of_run
);
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_kind <= K_ERROR) else $error("token kind out of range");
	a_bad_only_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != K_ERROR |-> bad_byte == 8'h00) else $error("bad byte set");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_END |-> last_of_run && token_length == 16'd0)
		else $error("end token not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind))
		else $error("stalled token changed");
endmodule

bind music_script_lexer_core msl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.token_kind(out_ch.token_kind), .token_length(out_ch.token_length),
	.bad_byte(out_ch.bad_byte), .last_of_run(out_ch.last_of_run)
);
